// File: src/diagonal_seed_run_merger_macros.svh
// Assertion macros used by the merger's top-level RTL file.
// Each macro samples on the rising edge of clk and is quiet while arst_n is low.
`ifndef DIAGONAL_SEED_RUN_MERGER_MACROS_SVH
`define DIAGONAL_SEED_RUN_MERGER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every clock edge out of reset.
`define DSRM_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("merger assertion failed");

// A condition in one cycle that implies another in the next cycle.
`define DSRM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("merger assertion failed");

`else

`define DSRM_ASSERT(lbl, prop)
`define DSRM_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: src/dsrm_pkg.sv
`timescale 1ns / 1ps

package dsrm_pkg;

	// Widths of the port fields.
	localparam int FIELD_BITS = 31;
	localparam int WS_BITS    = 15;
	localparam int IDX_BITS   = 2;

	// Depth of the word queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;

	// Configuration register indexes.
	typedef enum logic [IDX_BITS-1:0] {
		REG_MERGE_MODE    = 2'd0,
		REG_WORD_SIZE     = 2'd1,
		REG_SAME_SEQUENCE = 2'd2
	} cfg_reg_t;

	// Merge modes.
	localparam logic MODE_DIRECT   = 1'b0;
	localparam logic MODE_INVERTED = 1'b1;

	// Reset values of the configuration registers.
	localparam logic               RST_MERGE_MODE    = MODE_DIRECT;
	localparam logic [WS_BITS-1:0] RST_WORD_SIZE     = 15'd12;
	localparam logic               RST_SAME_SEQUENCE = 1'b1;

	// Current configuration.
	typedef struct packed {
		logic               merge_mode;
		logic [WS_BITS-1:0] word_size;
		logic               same_sequence;
	} cfg_t;

	// Snapshot of one closed run, the word passed from front to back.
	typedef struct packed {
		logic [FIELD_BITS-1:0] first_pos1;
		logic [FIELD_BITS-1:0] first_pos2;
		logic [FIELD_BITS-1:0] prev_pos1;
		logic [FIELD_BITS-1:0] prev_pos2;
		logic [FIELD_BITS-1:0] run_len;
		logic                  last;
		logic                  eol;
	} seed_rec_t;

endpackage

// File: src/dsrm_queue.sv
`timescale 1ns / 1ps

module dsrm_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);
	localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
	localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

	logic [WIDTH-1:0]    mem_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic                do_push;
	logic                do_pop;

	assign full     = (count_q == CNT_FULL);
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!do_push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage, no reset needed.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: src/dsrm_front.sv
`timescale 1ns / 1ps

module dsrm_front import dsrm_pkg::*; #(
	parameter int POS_BITS = 31
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  hit_valid,
	output logic                  hit_ready,
	input  logic [FIELD_BITS-1:0] hit_pos1,
	input  logic [FIELD_BITS-1:0] hit_pos2,
	input  logic                  final_hit,
	output logic                  push,
	output seed_rec_t             push_rec,
	input  logic                  full
);

	localparam int LEN_BITS = (POS_BITS > WS_BITS) ? POS_BITS : WS_BITS;
	localparam int DW       = LEN_BITS + 3;
	localparam logic signed [DW-1:0] POS_MAX = $signed(DW'((64'd1 << POS_BITS) - 64'd1));
	localparam logic signed [DW-1:0] ONE_S   = DW'(1);

	// Open run state.
	logic                run_open_q;
	logic [POS_BITS-1:0] first1_q;
	logic [POS_BITS-1:0] first2_q;
	logic [POS_BITS-1:0] prev1_q;
	logic [POS_BITS-1:0] prev2_q;
	logic [LEN_BITS-1:0] run_len_q;

	// Two word slots waiting for the queue.
	logic      a_v_q;
	logic      b_v_q;
	seed_rec_t a_rec_q;
	seed_rec_t b_rec_q;

	logic [POS_BITS-1:0] p1;
	logic [POS_BITS-1:0] p2;
	logic signed [DW-1:0] p1_x, p2_x, f1_x, f2_x, v1_x, len_x, ws_x;
	logic signed [DW-1:0] key_new_d, key_run_d, key_new_i, key_run_i;
	logic signed [DW-1:0] off, gap, reach;
	logic [LEN_BITS-1:0] reach_clamped;
	logic                join_d, join_i, joins, brk, accept;
	logic [POS_BITS-1:0] nxt_first1, nxt_first2;
	logic [LEN_BITS-1:0] nxt_len;
	seed_rec_t           old_rec, fin_rec;

	assign p1 = hit_pos1[POS_BITS-1:0];
	assign p2 = hit_pos2[POS_BITS-1:0];

	// Zero-extended operands for signed arithmetic.
	assign p1_x  = DW'(p1);
	assign p2_x  = DW'(p2);
	assign f1_x  = DW'(first1_q);
	assign f2_x  = DW'(first2_q);
	assign v1_x  = DW'(prev1_q);
	assign len_x = DW'(run_len_q);
	assign ws_x  = DW'(cfg.word_size);

	// Classify the hit against the open run.
	assign key_new_d = p2_x - p1_x;
	assign key_run_d = f2_x - f1_x;
	assign key_new_i = p1_x + p2_x;
	assign key_run_i = f1_x + f2_x;
	assign off       = p1_x - f1_x;
	assign gap       = p1_x - v1_x;
	assign join_d    = (key_new_d == key_run_d) && (off <= len_x);
	assign join_i    = (key_new_i == key_run_i) && (gap <= ws_x);
	assign joins     = run_open_q &&
		((cfg.merge_mode == MODE_INVERTED) ? join_i : join_d);
	assign brk       = run_open_q && !joins;

	// Reach of the joined hit, clamped to the legal length range.
	assign reach = off + ws_x;
	always_comb begin
		if (reach < ONE_S) begin
			reach_clamped = LEN_BITS'(1);
		end else if (reach > POS_MAX) begin
			reach_clamped = LEN_BITS'(POS_MAX);
		end else begin
			reach_clamped = reach[LEN_BITS-1:0];
		end
	end

	// Run state after this hit.
	always_comb begin
		if (joins) begin
			nxt_first1 = first1_q;
			nxt_first2 = first2_q;
			if (cfg.merge_mode == MODE_INVERTED) begin
				nxt_len = reach_clamped;
			end else if (reach > len_x) begin
				nxt_len = reach_clamped;
			end else begin
				nxt_len = run_len_q;
			end
		end else begin
			nxt_first1 = p1;
			nxt_first2 = p2;
			nxt_len    = LEN_BITS'(cfg.word_size);
		end
	end

	// Words for the run that breaks and for the run flushed by a final hit.
	always_comb begin
		old_rec.first_pos1 = FIELD_BITS'(first1_q);
		old_rec.first_pos2 = FIELD_BITS'(first2_q);
		old_rec.prev_pos1  = FIELD_BITS'(prev1_q);
		old_rec.prev_pos2  = FIELD_BITS'(prev2_q);
		old_rec.run_len    = FIELD_BITS'(run_len_q);
		old_rec.last       = !final_hit;
		old_rec.eol        = 1'b0;
		fin_rec.first_pos1 = FIELD_BITS'(nxt_first1);
		fin_rec.first_pos2 = FIELD_BITS'(nxt_first2);
		fin_rec.prev_pos1  = FIELD_BITS'(p1);
		fin_rec.prev_pos2  = FIELD_BITS'(p2);
		fin_rec.run_len    = FIELD_BITS'(nxt_len);
		fin_rec.last       = 1'b1;
		fin_rec.eol        = 1'b1;
	end

	// Handshake: slot A drains into the queue, slot B must be empty to take a hit.
	assign push      = a_v_q && !full;
	assign push_rec  = a_rec_q;
	assign hit_ready = !b_v_q && (!a_v_q || push);
	assign accept    = hit_valid && hit_ready;

	// Run state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_open_q <= 1'b0;
			first1_q   <= '0;
			first2_q   <= '0;
			prev1_q    <= '0;
			prev2_q    <= '0;
			run_len_q  <= '0;
		end else if (accept) begin
			run_open_q <= !final_hit;
			first1_q   <= nxt_first1;
			first2_q   <= nxt_first2;
			prev1_q    <= p1;
			prev2_q    <= p2;
			run_len_q  <= nxt_len;
		end
	end

	// Slot valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_v_q <= 1'b0;
			b_v_q <= 1'b0;
		end else if (accept) begin
			a_v_q <= brk || final_hit;
			b_v_q <= brk && final_hit;
		end else if (push) begin
			a_v_q <= b_v_q;
			b_v_q <= 1'b0;
		end
	end

	// Slot payloads.
	always_ff @(posedge clk) begin
		if (accept) begin
			a_rec_q <= brk ? old_rec : fin_rec;
			b_rec_q <= fin_rec;
		end else if (push) begin
			a_rec_q <= b_rec_q;
		end
	end

endmodule

// File: src/dsrm_back.sv
`timescale 1ns / 1ps

module dsrm_back import dsrm_pkg::*; #(
	parameter int POS_BITS = 31
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  seed_rec_t             rec,
	input  logic                  rec_empty,
	output logic                  rec_pop,
	output logic                  seed_valid,
	input  logic                  seed_ready,
	output logic [FIELD_BITS-1:0] seed_pos1,
	output logic [FIELD_BITS-1:0] seed_pos2,
	output logic [FIELD_BITS-1:0] seed_length,
	output logic                  is_direct,
	output logic                  last_of_burst,
	output logic                  end_of_list
);

	localparam int LEN_BITS = (POS_BITS > WS_BITS) ? POS_BITS : WS_BITS;
	localparam int DW       = LEN_BITS + 3;
	localparam logic signed [DW-1:0] POS_MAX = $signed(DW'((64'd1 << POS_BITS) - 64'd1));
	localparam logic signed [DW-1:0] ONE_S   = DW'(1);

	logic [POS_BITS-1:0]  fp1, fp2, pv1, pv2;
	logic signed [DW-1:0] fp1_x, pv1_x, pv2_x, ws_x, len_x;
	logic signed [DW-1:0] len_inv, d2;
	logic                 fix;
	logic                 adv;

	// Stage 1 registers.
	logic                 v_s1;
	logic                 mode_s1;
	logic                 fix_s1;
	logic signed [DW-1:0] len_s1;
	logic signed [DW-1:0] d2_s1;
	logic [POS_BITS-1:0]  p1_s1;
	logic [POS_BITS-1:0]  p2_s1;
	logic                 last_s1;
	logic                 eol_s1;

	// Output register.
	logic                  out_v_q;
	logic [FIELD_BITS-1:0] out_p1_q;
	logic [FIELD_BITS-1:0] out_p2_q;
	logic [FIELD_BITS-1:0] out_len_q;
	logic                  out_dir_q;
	logic                  out_last_q;
	logic                  out_eol_q;

	logic signed [DW-1:0] len_raw;
	logic [POS_BITS-1:0]  len_clamped;

	// The whole pipe moves when the output word is free or taken.
	assign adv     = !out_v_q || seed_ready;
	assign rec_pop = adv && !rec_empty;

	assign fp1   = rec.first_pos1[POS_BITS-1:0];
	assign fp2   = rec.first_pos2[POS_BITS-1:0];
	assign pv1   = rec.prev_pos1[POS_BITS-1:0];
	assign pv2   = rec.prev_pos2[POS_BITS-1:0];
	assign fp1_x = DW'(fp1);
	assign pv1_x = DW'(pv1);
	assign pv2_x = DW'(pv2);
	assign ws_x  = DW'(cfg.word_size);
	assign len_x = DW'(rec.run_len[LEN_BITS-1:0]);

	// Inverted seed: span length and the palindrome test.
	assign len_inv = ws_x + pv1_x - fp1_x;
	assign d2      = pv2_x - fp1_x;
	assign fix     = cfg.same_sequence && (ws_x + pv1_x > pv2_x + ONE_S);

	// Stage 1: length terms and the second position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= !rec_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s1 <= cfg.merge_mode;
			fix_s1  <= (cfg.merge_mode == MODE_INVERTED) && fix;
			len_s1  <= (cfg.merge_mode == MODE_INVERTED) ? len_inv : len_x;
			d2_s1   <= d2;
			p1_s1   <= fp1;
			if (cfg.merge_mode == MODE_DIRECT) begin
				p2_s1 <= fp2;
			end else begin
				p2_s1 <= fix ? fp1 : pv2;
			end
			last_s1 <= rec.last;
			eol_s1  <= rec.eol;
		end
	end

	// Final length, clamped to the legal range.
	assign len_raw = fix_s1 ? (len_s1 + d2_s1) : len_s1;
	always_comb begin
		if (len_raw < ONE_S) begin
			len_clamped = POS_BITS'(1);
		end else if (len_raw > POS_MAX) begin
			len_clamped = POS_BITS'(POS_MAX);
		end else begin
			len_clamped = len_raw[POS_BITS-1:0];
		end
	end

	// Output word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_p1_q   <= FIELD_BITS'(p1_s1);
			out_p2_q   <= FIELD_BITS'(p2_s1);
			out_len_q  <= FIELD_BITS'(len_clamped);
			out_dir_q  <= (mode_s1 == MODE_DIRECT);
			out_last_q <= last_s1;
			out_eol_q  <= eol_s1;
		end
	end

	assign seed_valid    = out_v_q;
	assign seed_pos1     = out_p1_q;
	assign seed_pos2     = out_p2_q;
	assign seed_length   = out_len_q;
	assign is_direct     = out_dir_q;
	assign last_of_burst = out_last_q;
	assign end_of_list   = out_eol_q;

endmodule

// File: src/diagonal_seed_run_merger.sv
// A seed word passes the front's word slot, the word queue, stage 1 and the output register.
// Throughput: one hit per cycle while the word slots drain; a hit that both breaks a run and
// flushes one puts two seed words out, and the front's second slot then holds off the next hit.
// Sustained output: one seed word per cycle while seed_ready is high (single-entry queue pop).
// Reset (arst_n low) closes any open run, empties the queue and pipe, and restores the
// configuration defaults; no clearing pass is needed.
`timescale 1ns / 1ps
`include "diagonal_seed_run_merger_macros.svh"

module diagonal_seed_run_merger import dsrm_pkg::*; #(
	parameter int POS_BITS = 31
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [IDX_BITS-1:0]   cfg_index,
	input  logic [WS_BITS-1:0]    cfg_data,
	input  logic                  hit_valid,
	output logic                  hit_ready,
	input  logic [FIELD_BITS-1:0] hit_pos1,
	input  logic [FIELD_BITS-1:0] hit_pos2,
	input  logic                  final_hit,
	output logic                  seed_valid,
	input  logic                  seed_ready,
	output logic [FIELD_BITS-1:0] seed_pos1,
	output logic [FIELD_BITS-1:0] seed_pos2,
	output logic [FIELD_BITS-1:0] seed_length,
	output logic                  is_direct,
	output logic                  last_of_burst,
	output logic                  end_of_list
);

	localparam int REC_BITS = $bits(seed_rec_t);

	cfg_t      cfg_q;
	logic      q_push, q_full, q_pop, q_empty;
	seed_rec_t q_wdata, q_rdata;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.merge_mode    <= RST_MERGE_MODE;
			cfg_q.word_size     <= RST_WORD_SIZE;
			cfg_q.same_sequence <= RST_SAME_SEQUENCE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MERGE_MODE: begin
					cfg_q.merge_mode <= cfg_data[0];
				end
				REG_WORD_SIZE: begin
					cfg_q.word_size <= cfg_data;
				end
				REG_SAME_SEQUENCE: begin
					cfg_q.same_sequence <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// Front: classifies hits and keeps the open run.
	dsrm_front #(
		.POS_BITS (POS_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.hit_valid (hit_valid),
		.hit_ready (hit_ready),
		.hit_pos1  (hit_pos1),
		.hit_pos2  (hit_pos2),
		.final_hit (final_hit),
		.push      (q_push),
		.push_rec  (q_wdata),
		.full      (q_full)
	);

	// Word queue between front and back.
	dsrm_queue #(
		.WIDTH (REC_BITS),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.empty     (q_empty)
	);

	// Back: finishes seed lengths and drives the output.
	dsrm_back #(
		.POS_BITS (POS_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.rec           (q_rdata),
		.rec_empty     (q_empty),
		.rec_pop       (q_pop),
		.seed_valid    (seed_valid),
		.seed_ready    (seed_ready),
		.seed_pos1     (seed_pos1),
		.seed_pos2     (seed_pos2),
		.seed_length   (seed_length),
		.is_direct     (is_direct),
		.last_of_burst (last_of_burst),
		.end_of_list   (end_of_list)
	);

	// Every seed has a length of at least one.
	`DSRM_ASSERT(a_len_nonzero, !seed_valid || (seed_length != '0))
	// The word that ends the list is always the last of its burst.
	`DSRM_ASSERT(a_eol_is_last, !(seed_valid && end_of_list) || last_of_burst)
	// A full queue is never reported empty.
	`DSRM_ASSERT(a_queue_state, !(q_full && q_empty))
	// After a final hit the front takes a new hit only while draining its flush word.
	`DSRM_ASSERT_NEXT(a_flush_drains, hit_valid && hit_ready && final_hit, !hit_ready || q_push)

endmodule
